>>> design/esa_pkg.sv
package esa_pkg;

    localparam int DATA_W  = 32;
    localparam int DEPTH_W = 7;

    // Operation codes carried in the func field
    typedef enum logic [3:0] {
        FN_PUSH = 4'd0,
        FN_POP  = 4'd1,
        FN_ADD  = 4'd2,
        FN_SUB  = 4'd3,
        FN_NEG  = 4'd4,
        FN_MUL  = 4'd5,
        FN_DIV  = 4'd6,
        FN_REM  = 4'd7,
        FN_AND  = 4'd8,
        FN_OR   = 4'd9,
        FN_XOR  = 4'd10,
        FN_CPL  = 4'd11,
        FN_SHR  = 4'd12,
        FN_SHL  = 4'd13,
        FN_LO   = 4'd14,
        FN_HI   = 4'd15
    } func_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_DIVZERO   = 2'd3
    } status_t;

    localparam logic [DATA_W-1:0] LO_MASK   = 32'h0000_00ff;
    localparam int                HI_SHIFT  = 8;

endpackage

>>> design/esa_ram.sv
module esa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write one entry, register the read word
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> design/esa_div.sv
module esa_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [esa_pkg::DATA_W-1:0] dividend,
    input  logic [esa_pkg::DATA_W-1:0] divisor,
    output logic                      done,
    output logic [esa_pkg::DATA_W-1:0] quotient,
    output logic [esa_pkg::DATA_W-1:0] remainder
);

    localparam int W  = esa_pkg::DATA_W;
    localparam int SW = $clog2(W);

    logic          busy_reg;
    logic          done_reg;
    logic [SW-1:0] step_reg;
    logic [W-1:0]  quo_reg;
    logic [W-1:0]  rem_reg;
    logic [W-1:0]  dvs_reg;
    logic [W:0]    shifted;
    logic [W:0]    trial;

    // Shift in the next dividend bit and try the subtraction
    assign shifted = {rem_reg, quo_reg[W-1]};
    assign trial   = shifted - {1'b0, dvs_reg};

    // Sequence the iterations
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + SW'(1);
            if (step_reg == SW'(W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Restoring division, one quotient bit a cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (!trial[W])
            begin
                rem_reg <= trial[W-1:0];
                quo_reg <= {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[W-1:0];
                quo_reg <= {quo_reg[W-2:0], 1'b0};
            end
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

`ifndef SYNTHESIS
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(done_reg) |-> $past(busy_reg))
        else $error("divider finished without running");
    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !done_reg)
        else $error("divider done while still busy");
    a_busy_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !start && step_reg != SW'(W - 1)) |=> busy_reg)
        else $error("divider stopped early");
`endif

endmodule

>>> design/expression_stack_alu.sv
// Reverse Polish stack evaluator for 32-bit signed words. Each input word is a
// push or an operation on the top entries of a STACK_DEPTH-entry stack held in
// a single-port-write, registered-read memory; the top entry is also kept in a
// register. Every input word yields one result word carrying the new top (the
// popped value for pop), a status and the depth. One word is worked at a time:
// most operations go from acceptance through a load state, which uses the entry
// below the top as read from the memory, and a commit stage that presents the
// result; the next word is taken once the sequencer is idle again. Divide and
// remainder by a non-zero divisor without deferral add a divide state between
// load and commit, waiting on the one-bit-per-cycle restoring divider. A result
// still held by out_stall delays the commit of the following word. Stack entries
// need no clearing after reset.
module expression_stack_alu #(
    parameter int STACK_DEPTH = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic               cfg_wr_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [3:0]         func,
    input  logic signed [31:0] operand,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] top_value,
    output logic [1:0]         status,
    output logic [6:0]         depth
);

    localparam int W  = esa_pkg::DATA_W;
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int XW = (CW > esa_pkg::DEPTH_W) ? CW : esa_pkg::DEPTH_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_DIV,
        S_COMMIT
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic [CW-1:0]      count_reg;
    logic [W-1:0]       top_reg;
    logic               defer_reg;
    esa_pkg::func_t     func_reg;
    logic [W-1:0]       operand_reg;

    logic               out_valid_reg;
    logic [W-1:0]       top_value_reg;
    esa_pkg::status_t   status_reg;
    logic [esa_pkg::DEPTH_W-1:0] depth_reg;

    esa_pkg::status_t   st_status_reg;
    logic [CW-1:0]      st_count_reg;
    logic [W-1:0]       st_top_reg;
    logic               st_we_reg;
    logic [AW-1:0]      st_waddr_reg;
    logic               st_pop_reg;
    logic               a_neg_reg;
    logic               b_neg_reg;

    logic               in_accept;
    logic               commit_fire;
    logic [CW-1:0]      cnt_m1;
    logic [CW-1:0]      cnt_m2;
    logic [W-1:0]       a_word;
    logic [W-1:0]       b_word;
    logic [1:0]         need;

    esa_pkg::status_t   ld_status;
    logic [CW-1:0]      ld_count;
    logic [W-1:0]       ld_top;
    logic               ld_we;
    logic [AW-1:0]      ld_waddr;
    logic               ld_pop;
    logic               ld_div;

    logic               div_done;
    logic [W-1:0]       div_quo;
    logic [W-1:0]       div_rem;
    logic [W-1:0]       div_fixed;
    logic [XW-1:0]      cnt_wide;

    assign in_stall    = (state_reg != S_IDLE);
    assign in_accept   = in_valid && !in_stall;
    assign commit_fire = (state_reg == S_COMMIT) && (!out_valid_reg || !out_stall);

    assign cnt_m1 = count_reg - CW'(1);
    assign cnt_m2 = count_reg - CW'(2);
    assign b_word = top_reg;

    // Stack storage
    esa_ram #(
        .WIDTH (W),
        .DEPTH (STACK_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (commit_fire && st_we_reg),
        .wr_addr (st_waddr_reg),
        .wr_data (st_top_reg),
        .rd_en   (in_accept),
        .rd_addr (cnt_m2[AW-1:0]),
        .rd_data (a_word)
    );

    // Iterative divider on magnitudes
    esa_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     ((state_reg == S_LOAD) && ld_div),
        .dividend  (a_word[W-1] ? (W'(0) - a_word) : a_word),
        .divisor   (b_word[W-1] ? (W'(0) - b_word) : b_word),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // Restore signs: quotient by sign mismatch, remainder follows the dividend
    always_comb
    begin
        if (func_reg == esa_pkg::FN_DIV)
        begin
            div_fixed = (a_neg_reg != b_neg_reg) ? (W'(0) - div_quo) : div_quo;
        end
        else
        begin
            div_fixed = a_neg_reg ? (W'(0) - div_rem) : div_rem;
        end
    end

    // Count entries the operation consumes
    always_comb
    begin
        case (func_reg)
            esa_pkg::FN_PUSH: need = 2'd0;
            esa_pkg::FN_POP,
            esa_pkg::FN_NEG,
            esa_pkg::FN_CPL,
            esa_pkg::FN_LO,
            esa_pkg::FN_HI:   need = 2'd1;
            default:          need = 2'd2;
        endcase
    end

    // Decode the word once the entry below the top has been read
    always_comb
    begin
        ld_status = esa_pkg::ST_OK;
        ld_count  = count_reg;
        ld_top    = top_reg;
        ld_we     = 1'b0;
        ld_waddr  = cnt_m2[AW-1:0];
        ld_pop    = 1'b0;
        ld_div    = 1'b0;
        if (func_reg == esa_pkg::FN_PUSH)
        begin
            if (count_reg == CW'(STACK_DEPTH))
            begin
                ld_status = esa_pkg::ST_OVERFLOW;
            end
            else
            begin
                ld_we    = 1'b1;
                ld_waddr = count_reg[AW-1:0];
                ld_top   = operand_reg;
                ld_count = count_reg + CW'(1);
            end
        end
        else if (count_reg < CW'(need))
        begin
            ld_status = esa_pkg::ST_UNDERFLOW;
        end
        else
        begin
            case (func_reg)
                esa_pkg::FN_POP:
                begin
                    ld_pop   = 1'b1;
                    ld_count = cnt_m1;
                    ld_top   = a_word;
                end
                esa_pkg::FN_NEG,
                esa_pkg::FN_CPL,
                esa_pkg::FN_LO,
                esa_pkg::FN_HI:
                begin
                    ld_we    = 1'b1;
                    ld_waddr = cnt_m1[AW-1:0];
                    case (func_reg)
                        esa_pkg::FN_NEG: ld_top = W'(0) - b_word;
                        esa_pkg::FN_CPL: ld_top = ~b_word;
                        esa_pkg::FN_LO:  ld_top = b_word & esa_pkg::LO_MASK;
                        default:         ld_top = $signed(b_word) >>> esa_pkg::HI_SHIFT;
                    endcase
                end
                esa_pkg::FN_DIV,
                esa_pkg::FN_REM:
                begin
                    if (defer_reg)
                    begin
                        ld_count = cnt_m1;
                        ld_top   = a_word;
                    end
                    else if (b_word == '0)
                    begin
                        ld_status = esa_pkg::ST_DIVZERO;
                    end
                    else
                    begin
                        ld_div   = 1'b1;
                        ld_count = cnt_m1;
                        ld_we    = 1'b1;
                    end
                end
                default:
                begin
                    ld_count = cnt_m1;
                    ld_we    = 1'b1;
                    case (func_reg)
                        esa_pkg::FN_ADD: ld_top = a_word + b_word;
                        esa_pkg::FN_SUB: ld_top = a_word - b_word;
                        esa_pkg::FN_MUL: ld_top = a_word * b_word;
                        esa_pkg::FN_AND: ld_top = a_word & b_word;
                        esa_pkg::FN_OR:  ld_top = a_word | b_word;
                        esa_pkg::FN_XOR: ld_top = a_word ^ b_word;
                        esa_pkg::FN_SHR: ld_top = $signed(a_word) >>> b_word[4:0];
                        default:         ld_top = a_word << b_word[4:0];
                    endcase
                end
            endcase
        end
    end

    // Advance the sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                state_next = ld_div ? S_DIV : S_COMMIT;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                if (commit_fire)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold control state, count, deferral flag and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            defer_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                defer_reg <= cfg_wr_data;
            end
            if (commit_fire)
            begin
                count_reg     <= st_count_reg;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign cnt_wide = XW'(st_count_reg);

    // Capture the word, stage the update, load the result
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            func_reg    <= esa_pkg::func_t'(func);
            operand_reg <= operand;
        end
        if (state_reg == S_LOAD)
        begin
            st_status_reg <= ld_status;
            st_count_reg  <= ld_count;
            st_top_reg    <= ld_top;
            st_we_reg     <= ld_we;
            st_waddr_reg  <= ld_waddr;
            st_pop_reg    <= ld_pop;
            a_neg_reg     <= a_word[W-1];
            b_neg_reg     <= b_word[W-1];
        end
        else if ((state_reg == S_DIV) && div_done)
        begin
            st_top_reg <= div_fixed;
        end
        if (commit_fire)
        begin
            top_reg    <= st_top_reg;
            status_reg <= st_status_reg;
            depth_reg  <= cnt_wide[esa_pkg::DEPTH_W-1:0];
            if (st_pop_reg)
            begin
                top_value_reg <= top_reg;
            end
            else
            begin
                top_value_reg <= (st_count_reg != '0) ? st_top_reg : '0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign top_value = top_value_reg;
    assign status    = status_reg;
    assign depth     = depth_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(STACK_DEPTH))
        else $error("entry count beyond stack depth");
    a_count_on_commit: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> $past(commit_fire))
        else $error("entry count changed outside commit");
    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
        else $error("divider result with no division pending");
    a_result_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_COMMIT))
        else $error("result word raised without commit");
`endif

endmodule
